>>> rtl/visual_servo_pid_steering_top_macros.svh
// Assertion macros for the visual servo PID steering block.
// Used by the checker module; no other dependencies.
`ifndef VISUAL_SERVO_PID_STEERING_TOP_MACROS_SVH
`define VISUAL_SERVO_PID_STEERING_TOP_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define VSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define VSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/vsp_pkg.sv
// Shared types, constants and arithmetic helpers for the visual servo PID steering block.
// No dependencies.
`default_nettype none

package vsp_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KP_TURN          = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_TURN          = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_TURN          = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KP_APPROACH      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KI_APPROACH      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KD_APPROACH      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_TOLERANCE = 8'd7;

    // Register reset values.
    localparam logic [31:0] RST_KP_TURN          = 32'd4294967;
    localparam logic [31:0] RST_KI_TURN          = 32'd429;
    localparam logic [31:0] RST_KD_TURN          = 32'd4294967;
    localparam logic [31:0] RST_KP_APPROACH      = 32'd85899346;
    localparam logic [31:0] RST_KI_APPROACH      = 32'd0;
    localparam logic [31:0] RST_KD_APPROACH      = 32'd0;
    localparam logic [9:0]  RST_TARGET_HEIGHT    = 10'd300;
    localparam logic [9:0]  RST_CENTRE_TOLERANCE = 10'd40;

    // Search turn rate of 0.3 in Q16 and the arrival margin in pixels.
    localparam logic signed [31:0] SEARCH_TURN_Q16 = 32'sd19661;
    localparam logic signed [11:0] REACH_MARGIN    = 12'sd10;

    // Which branch of the controller a frame takes.
    typedef enum logic [1:0] {
        MODE_SEARCH,
        MODE_TURN,
        MODE_APPROACH,
        MODE_REACHED
    } t_mode;

    // Saturating add of a 12-bit error into a 32-bit integral sum.
    function automatic logic signed [31:0] add_sat32(input logic signed [31:0] a,
                                                     input logic signed [11:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) begin
            add_sat32 = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            add_sat32 = s[31:0];
        end
    endfunction

    // Saturate a 50-bit Q16 value to 32 bits signed.
    function automatic logic signed [31:0] sat_q16(input logic signed [49:0] v);
        if (v[49:31] == {19{v[49]}}) begin
            sat_q16 = v[31:0];
        end else begin
            sat_q16 = v[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/vsp_if.sv
// Channel interfaces for the visual servo PID steering block: detections in,
// steering commands out, and configuration writes. Depends on vsp_pkg.
`default_nettype none

// Detection channel, one transaction per camera frame.
interface vsp_in_if;
    logic       valid;
    logic       ready;
    logic       target_found;
    logic [9:0] centre_x;
    logic [9:0] object_height;

    modport source (output valid, output target_found, output centre_x,
                    output object_height, input ready);
    modport sink   (input valid, input target_found, input centre_x,
                    input object_height, output ready);
endinterface

// Steering command channel.
interface vsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] turn_rate;
    logic signed [31:0] forward_speed;
    logic               target_reached;

    modport source (output valid, output turn_rate, output forward_speed,
                    output target_reached, input ready);
    modport sink   (input valid, input turn_rate, input forward_speed,
                    input target_reached, output ready);
endinterface

// Configuration write channel.
interface vsp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [vsp_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/visual_servo_pid_steering_top.sv
// Throughput: one detection per cycle through the four-stage pipeline
// (input, operand, product and output registers); a stall at the output backs up the stages.
// Reset (synchronous, active low) empties the pipeline, zeroes the integral sums
// and previous errors, and loads the default gains and thresholds.
`default_nettype none

module visual_servo_pid_steering_top #(
    parameter int IMAGE_WIDTH = 640
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    vsp_in_if.sink      i_in,
    vsp_out_if.source   o_out,
    vsp_cfg_if.sink     i_cfg
);

    localparam logic [11:0] HALF_WIDTH = 12'(IMAGE_WIDTH / 2);

    // Configuration registers.
    logic [31:0] r_kp_turn, r_ki_turn, r_kd_turn;
    logic [31:0] r_kp_approach, r_ki_approach, r_kd_approach;
    logic [9:0]  r_target_height, r_centre_tolerance;

    // Controller state.
    logic signed [31:0] r_turn_sum, r_approach_sum;
    logic signed [11:0] r_turn_last, r_approach_last;

    // Pipeline valid flags and stage enables.
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // Stage 1: captured detection.
    logic       r_found;
    logic [9:0] r_centre_x, r_object_height;

    // Stage 2: selected PID operands.
    vsp_pkg::t_mode     r2_mode;
    logic signed [11:0] r2_err;
    logic signed [12:0] r2_diff;
    logic signed [31:0] r2_sum;
    logic [31:0]        r2_kp, r2_ki, r2_kd;

    // Stage 3: products.
    vsp_pkg::t_mode     r3_mode;
    logic signed [44:0] r3_p;
    logic signed [64:0] r3_i;
    logic signed [45:0] r3_d;

    // Stage 4: output register.
    logic signed [31:0] r_turn_rate, r_forward_speed;
    logic               r_target_reached;

    // Stage 2 combinational values.
    logic signed [13:0] n_ea_wide;
    logic signed [11:0] n_ea, n_eh;
    logic signed [12:0] n_ea_neg;
    logic [11:0]        n_mag;
    vsp_pkg::t_mode     n_mode;
    logic signed [11:0] n_err;
    logic signed [12:0] n_diff;
    logic signed [31:0] n_sum;
    logic [31:0]        n_kp, n_ki, n_kd;

    // Stage 4 combinational values.
    logic signed [65:0] n_total;
    logic signed [31:0] n_pid;
    logic signed [31:0] n_turn_rate, n_forward_speed;
    logic               n_target_reached;

    // Pipeline flow control: a stage moves when the one after it can take its item.
    assign en4 = !r_v4 || o_out.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready  = en1;
    assign i_cfg.ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_turn          <= vsp_pkg::RST_KP_TURN;
            r_ki_turn          <= vsp_pkg::RST_KI_TURN;
            r_kd_turn          <= vsp_pkg::RST_KD_TURN;
            r_kp_approach      <= vsp_pkg::RST_KP_APPROACH;
            r_ki_approach      <= vsp_pkg::RST_KI_APPROACH;
            r_kd_approach      <= vsp_pkg::RST_KD_APPROACH;
            r_target_height    <= vsp_pkg::RST_TARGET_HEIGHT;
            r_centre_tolerance <= vsp_pkg::RST_CENTRE_TOLERANCE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                vsp_pkg::REG_KP_TURN:          r_kp_turn          <= i_cfg.data;
                vsp_pkg::REG_KI_TURN:          r_ki_turn          <= i_cfg.data;
                vsp_pkg::REG_KD_TURN:          r_kd_turn          <= i_cfg.data;
                vsp_pkg::REG_KP_APPROACH:      r_kp_approach      <= i_cfg.data;
                vsp_pkg::REG_KI_APPROACH:      r_ki_approach      <= i_cfg.data;
                vsp_pkg::REG_KD_APPROACH:      r_kd_approach      <= i_cfg.data;
                vsp_pkg::REG_TARGET_HEIGHT:    r_target_height    <= i_cfg.data[9:0];
                vsp_pkg::REG_CENTRE_TOLERANCE: r_centre_tolerance <= i_cfg.data[9:0];
                default: ;
            endcase
        end
    end

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Stage 1: capture the detection on each input transaction.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && en1) begin
            r_found         <= i_in.target_found;
            r_centre_x      <= i_in.centre_x;
            r_object_height <= i_in.object_height;
        end
    end

    // Errors, branch choice and operand selection.
    always_comb begin
        n_ea_wide = $signed({2'b00, HALF_WIDTH}) - $signed({4'b0000, r_centre_x});
        if (n_ea_wide > 14'sd2047) begin
            n_ea = 12'sd2047;
        end else if (n_ea_wide < -14'sd2048) begin
            n_ea = -12'sd2048;
        end else begin
            n_ea = n_ea_wide[11:0];
        end
        n_eh     = $signed({2'b00, r_target_height}) - $signed({2'b00, r_object_height});
        n_ea_neg = -13'(n_ea);
        n_mag    = n_ea[11] ? n_ea_neg[11:0] : n_ea[11:0];

        if (!r_found) begin
            n_mode = vsp_pkg::MODE_SEARCH;
        end else if (n_mag >= {2'b00, r_centre_tolerance}) begin
            n_mode = vsp_pkg::MODE_TURN;
        end else if (n_eh < vsp_pkg::REACH_MARGIN) begin
            n_mode = vsp_pkg::MODE_REACHED;
        end else begin
            n_mode = vsp_pkg::MODE_APPROACH;
        end

        // The turn loop is the default operand set; the approach loop replaces it.
        if (n_mode == vsp_pkg::MODE_APPROACH) begin
            n_err  = n_eh;
            n_diff = 13'(n_eh) - 13'(r_approach_last);
            n_sum  = vsp_pkg::add_sat32(r_approach_sum, n_eh);
            n_kp   = r_kp_approach;
            n_ki   = r_ki_approach;
            n_kd   = r_kd_approach;
        end else begin
            n_err  = n_ea;
            n_diff = 13'(n_ea) - 13'(r_turn_last);
            n_sum  = vsp_pkg::add_sat32(r_turn_sum, n_ea);
            n_kp   = r_kp_turn;
            n_ki   = r_ki_turn;
            n_kd   = r_kd_turn;
        end
    end

    // Controller state update as each frame leaves stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_sum      <= '0;
            r_approach_sum  <= '0;
            r_turn_last     <= '0;
            r_approach_last <= '0;
        end else if (r_v1 && en2) begin
            if (n_mode == vsp_pkg::MODE_TURN) begin
                r_turn_sum <= n_sum;
            end
            if (n_mode == vsp_pkg::MODE_APPROACH) begin
                r_approach_sum <= n_sum;
            end
            if (r_found) begin
                r_turn_last     <= n_ea;
                r_approach_last <= n_eh;
            end
        end
    end

    // Stage 2 registers.
    always_ff @(posedge i_clk) begin
        if (r_v1 && en2) begin
            r2_mode <= n_mode;
            r2_err  <= n_err;
            r2_diff <= n_diff;
            r2_sum  <= n_sum;
            r2_kp   <= n_kp;
            r2_ki   <= n_ki;
            r2_kd   <= n_kd;
        end
    end

    // Stage 3: the three gain products, each in its own multiplier.
    always_ff @(posedge i_clk) begin
        if (r_v2 && en3) begin
            r3_mode <= r2_mode;
            r3_p    <= r2_err * $signed({1'b0, r2_kp});
            r3_i    <= r2_sum * $signed({1'b0, r2_ki});
            r3_d    <= r2_diff * $signed({1'b0, r2_kd});
        end
    end

    // Sum the Q32 terms, floor to Q16, saturate, and form the command.
    always_comb begin
        n_total = 66'(r3_p) + 66'(r3_i) + 66'(r3_d);
        n_pid   = vsp_pkg::sat_q16($signed(n_total[65:16]));

        n_turn_rate      = '0;
        n_forward_speed  = '0;
        n_target_reached = 1'b0;
        case (r3_mode)
            vsp_pkg::MODE_SEARCH:   n_turn_rate      = vsp_pkg::SEARCH_TURN_Q16;
            vsp_pkg::MODE_TURN:     n_turn_rate      = n_pid;
            vsp_pkg::MODE_APPROACH: n_forward_speed  = n_pid;
            vsp_pkg::MODE_REACHED:  n_target_reached = 1'b1;
            default: ;
        endcase
    end

    // Stage 4: output register.
    always_ff @(posedge i_clk) begin
        if (r_v3 && en4) begin
            r_turn_rate      <= n_turn_rate;
            r_forward_speed  <= n_forward_speed;
            r_target_reached <= n_target_reached;
        end
    end

    assign o_out.valid          = r_v4;
    assign o_out.turn_rate      = r_turn_rate;
    assign o_out.forward_speed  = r_forward_speed;
    assign o_out.target_reached = r_target_reached;

endmodule

`default_nettype wire

>>> rtl/vsp_checker.sv
// Port-level assertions for the visual servo PID steering top level, bound to it below.
// Depends on the assertion macro header.
`default_nettype none

`include "visual_servo_pid_steering_top_macros.svh"

module vsp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_turn_rate,
    input wire [31:0] i_forward_speed,
    input wire        i_target_reached
);

    // The pipeline comes out of reset empty.
    `VSP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // Arrival commands a full stop.
    `VSP_ASSERT(a_reached_stop, i_clk, i_rst_n, i_out_valid && i_target_reached |-> i_turn_rate == 32'd0 && i_forward_speed == 32'd0, "arrival without stop")

    // Only one loop drives the vehicle in a frame.
    `VSP_ASSERT(a_one_loop, i_clk, i_rst_n, i_out_valid && i_forward_speed != 32'd0 |-> i_turn_rate == 32'd0, "turn and drive together")

    // A stalled command holds.
    `VSP_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_turn_rate) && $stable(i_forward_speed) && $stable(i_target_reached), "stalled command changed")

endmodule

bind visual_servo_pid_steering_top vsp_checker u_vsp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_turn_rate      (o_out.turn_rate),
    .i_forward_speed  (o_out.forward_speed),
    .i_target_reached (o_out.target_reached)
);

`default_nettype wire

>>> tb/sv/vsp_steer_checker.sv
// Passive checker for the visual servo PID steering block: watches the detection,
// command and configuration channels, predicts each command and compares it.
// Depends on vsp_pkg and the channel interfaces in vsp_if.sv.
module vsp_steer_checker #(
    parameter int IMAGE_WIDTH = 640
) (
    input  logic i_clk,
    input  logic i_rst_n,
    vsp_in_if    i_in,
    vsp_out_if   i_out,
    vsp_cfg_if   i_cfg,
    output int   o_failures,
    output int   o_pending
);
    import vsp_pkg::*;

    typedef struct packed {
        logic signed [31:0] turn;
        logic signed [31:0] fwd;
        logic               reached;
    } steer_cmd_t;

    // Shadow copy of the configuration registers.
    logic [31:0] kp_turn, ki_turn, kd_turn;
    logic [31:0] kp_appr, ki_appr, kd_appr;
    logic [9:0]  target_h, centre_tol;

    // Shadow copy of the controller state.
    int turn_sum, turn_prev, appr_sum, appr_prev;

    steer_cmd_t expected_cmds[$];
    int         fail_count = 0;
    int         cmd_count = 0;

    assign o_failures = fail_count;
    assign o_pending  = expected_cmds.size();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH command %0d: %s got %0d, predicted %0d",
                 cmd_count, what, got, want);
        fail_count++;
    endtask

    // Integral update, saturated to the 32-bit signed range.
    function automatic int sum_sat(input int acc, input int err);
        longint s;
        s = longint'(acc) + longint'(err);
        if (s > longint'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -longint'(32'h8000_0000)) begin
            return 32'sh8000_0000;
        end
        return int'(s);
    endfunction

    // Exact PID sum with Q32 gains, floored to Q16 and saturated to 32 bits.
    function automatic logic signed [31:0] pid_q16(input int err, input int acc, input int prev,
                                                   input logic [31:0] kp, input logic [31:0] ki,
                                                   input logic [31:0] kd);
        logic signed [65:0] p_term, i_term, d_term, total;
        p_term = 66'(err) * $signed({34'd0, kp});
        i_term = 66'(acc) * $signed({34'd0, ki});
        d_term = 66'(err - prev) * $signed({34'd0, kd});
        total  = (p_term + i_term + d_term) >>> 16;
        if (total > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (total < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return total[31:0];
    endfunction

    // Steering command for one detection; updates the shadow state.
    function automatic steer_cmd_t compute_steering(input logic found, input logic [9:0] cx,
                                                    input logic [9:0] h);
        int         ea, eh, mag;
        t_mode      mode;
        steer_cmd_t cmd;
        cmd  = '0;
        ea   = 0;
        eh   = 0;
        mode = MODE_SEARCH;
        if (found) begin
            ea = IMAGE_WIDTH / 2 - int'(cx);
            if (ea > 2047) ea = 2047;
            if (ea < -2048) ea = -2048;
            eh  = int'(target_h) - int'(h);
            mag = (ea < 0) ? -ea : ea;
            if (mag < int'(centre_tol)) begin
                mode = (eh < int'(REACH_MARGIN)) ? MODE_REACHED : MODE_APPROACH;
            end else begin
                mode = MODE_TURN;
            end
        end
        case (mode)
            MODE_SEARCH: begin
                cmd.turn = SEARCH_TURN_Q16;
            end
            MODE_TURN: begin
                turn_sum = sum_sat(turn_sum, ea);
                cmd.turn = pid_q16(ea, turn_sum, turn_prev, kp_turn, ki_turn, kd_turn);
            end
            MODE_APPROACH: begin
                appr_sum = sum_sat(appr_sum, eh);
                cmd.fwd  = pid_q16(eh, appr_sum, appr_prev, kp_appr, ki_appr, kd_appr);
            end
            default: begin
                cmd.reached = 1'b1;
            end
        endcase
        // Previous errors follow every frame that saw the target.
        if (found) begin
            turn_prev = ea;
            appr_prev = eh;
        end
        return cmd;
    endfunction

    // Register writes; unmapped indexes are dropped.
    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            REG_KP_TURN:          kp_turn    = data;
            REG_KI_TURN:          ki_turn    = data;
            REG_KD_TURN:          kd_turn    = data;
            REG_KP_APPROACH:      kp_appr    = data;
            REG_KI_APPROACH:      ki_appr    = data;
            REG_KD_APPROACH:      kd_appr    = data;
            REG_TARGET_HEIGHT:    target_h   = data[9:0];
            REG_CENTRE_TOLERANCE: centre_tol = data[9:0];
            default: ;
        endcase
    endtask

    // Sample every channel at the rising edge: compare commands, track writes, predict.
    always @(posedge i_clk) begin
        steer_cmd_t want;
        if (!i_rst_n) begin
            kp_turn    = RST_KP_TURN;
            ki_turn    = RST_KI_TURN;
            kd_turn    = RST_KD_TURN;
            kp_appr    = RST_KP_APPROACH;
            ki_appr    = RST_KI_APPROACH;
            kd_appr    = RST_KD_APPROACH;
            target_h   = RST_TARGET_HEIGHT;
            centre_tol = RST_CENTRE_TOLERANCE;
            turn_sum   = 0;
            turn_prev  = 0;
            appr_sum   = 0;
            appr_prev  = 0;
            expected_cmds.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch("unexpected command, turn_rate",
                                    longint'(i_out.turn_rate), 0);
                end else begin
                    want = expected_cmds.pop_front();
                    if (i_out.turn_rate !== want.turn)
                        report_mismatch("turn_rate", longint'(i_out.turn_rate),
                                        longint'(want.turn));
                    if (i_out.forward_speed !== want.fwd)
                        report_mismatch("forward_speed", longint'(i_out.forward_speed),
                                        longint'(want.fwd));
                    if (i_out.target_reached !== want.reached)
                        report_mismatch("target_reached", longint'(i_out.target_reached),
                                        longint'(want.reached));
                end
                cmd_count++;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                apply_write(i_cfg.index, i_cfg.data);
            end
            if (i_in.valid && i_in.ready) begin
                expected_cmds.push_back(compute_steering(i_in.target_found, i_in.centre_x,
                                                         i_in.object_height));
            end
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the steering block testbench: clock, reset, detection and configuration
// stimulus, command back-pressure and the verdict. Depends on vsp_pkg, vsp_if.sv,
// vsp_steer_checker.sv and the block itself.
module testbench;
    import vsp_pkg::*;

    localparam int IMAGE_WIDTH  = 640;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASES       = 8;
    localparam int PHASE_FRAMES = 230;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_CENTRE_TOLERANCE + 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    int failures;
    int pending;

    // Idling controls of the sender and the receiver.
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int gap_pct = 0;
    int stall_pct = 0;

    // Current thresholds, used to aim frames at the interesting regions.
    int cur_height = int'(RST_TARGET_HEIGHT);
    int cur_tol = int'(RST_CENTRE_TOLERANCE);

    vsp_in_if  in_ch();
    vsp_out_if out_ch();
    vsp_cfg_if cfg_ch();

    visual_servo_pid_steering_top #(.IMAGE_WIDTH(IMAGE_WIDTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    vsp_steer_checker #(.IMAGE_WIDTH(IMAGE_WIDTH)) u_steer_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg      (cfg_ch),
        .o_failures (failures),
        .o_pending  (pending)
    );

    // Clock with a period of 10.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Limit on the whole run.
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Command receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                out_ch.ready = 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                out_ch.ready = 1'b1;
            end
        end
    end

    function automatic int clip10(input int v);
        return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
    endfunction

    // Drop valid with junk on the payload and idle for the length given by n.
    task automatic in_idle(input int n);
        in_ch.valid = 1'b0;
        in_ch.target_found = 1'($urandom());
        in_ch.centre_x = 10'($urandom());
        in_ch.object_height = 10'($urandom());
        repeat (n) @(negedge i_clk);
    endtask

    // One detection transaction; valid stays high until the caller decides.
    task automatic push_frame(input logic found, input logic [9:0] cx, input logic [9:0] h);
        if (!quiet && $urandom_range(0, 99) < gap_pct) in_idle($urandom_range(1, 10));
        in_ch.valid = 1'b1;
        in_ch.target_found = found;
        in_ch.centre_x = cx;
        in_ch.object_height = h;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every command has come back.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Gain for a random setting: mostly modest, sometimes anywhere in range.
    function automatic logic [31:0] pick_gain();
        return ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 24);
    endfunction

    // Load one configuration setting; 10-bit registers get random upper bits.
    task automatic program_setting(input int phase);
        logic [31:0] g[6];
        logic [31:0] hw, tw;
        for (int k = 0; k < 6; k++) g[k] = pick_gain();
        hw = $urandom();
        tw = $urandom();
        hw[9:0] = 10'($urandom_range(0, 1023));
        tw[9:0] = 10'($urandom_range(0, 200));
        case (phase)
            1: begin
                foreach (g[k]) g[k] = 32'hFFFF_FFFF;
                hw[9:0] = 10'd1023;
                tw[9:0] = 10'd1023;
            end
            2: begin
                foreach (g[k]) g[k] = 32'd0;
                hw[9:0] = 10'd0;
                tw[9:0] = 10'd0;
            end
            3: begin
                g[0] = RST_KP_TURN;
                g[1] = $urandom_range(0, 1 << 20);
                g[2] = RST_KD_TURN;
                g[3] = RST_KP_APPROACH;
                hw[9:0] = RST_TARGET_HEIGHT;
                tw[9:0] = RST_CENTRE_TOLERANCE;
            end
            default: ;
        endcase
        // Writes to unmapped indexes must leave every register alone.
        write_reg(REG_UNMAPPED, $urandom());
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_UNMAPPED), 255)), $urandom());
        write_reg(REG_KP_TURN, g[0]);
        write_reg(REG_KI_TURN, g[1]);
        write_reg(REG_KD_TURN, g[2]);
        write_reg(REG_KP_APPROACH, g[3]);
        write_reg(REG_KI_APPROACH, g[4]);
        write_reg(REG_KD_APPROACH, g[5]);
        write_reg(REG_TARGET_HEIGHT, hw);
        write_reg(REG_CENTRE_TOLERANCE, tw);
        cur_height = int'(hw[9:0]);
        cur_tol = int'(tw[9:0]);
    endtask

    // Single random frame, often aimed at the edges of the dead band and the arrival height.
    task automatic random_frame();
        int r, cx, h;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            cx = $urandom_range(0, 1023);
        end else if (r < 5) begin
            cx = $urandom_range(0, IMAGE_WIDTH - 1);
        end else begin
            cx = clip10(IMAGE_WIDTH / 2 + $urandom_range(0, 2 * cur_tol + 16) - cur_tol - 8);
        end
        if ($urandom_range(0, 9) < 4) begin
            h = $urandom_range(0, 1023);
        end else begin
            h = clip10(cur_height + $urandom_range(0, 60) - 30);
        end
        push_frame($urandom_range(0, 7) != 0, 10'(cx), 10'(h));
    endtask

    // Mostly approach runs (centred, growing height) with single random frames between.
    task automatic random_frames(input int n);
        int sent, run, h, off;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 4) begin
                run = $urandom_range(4, 12);
                h = clip10(cur_height - $urandom_range(20, 200));
                for (int k = 0; k < run; k++) begin
                    off = (cur_tol > 0) ? $urandom_range(0, 2 * cur_tol - 2) - (cur_tol - 1) : 0;
                    push_frame(1'b1, 10'(clip10(IMAGE_WIDTH / 2 + off)), 10'(h));
                    h = clip10(h + $urandom_range(5, 40));
                end
                sent += run;
            end else begin
                random_frame();
                sent++;
            end
        end
    endtask

    // Main stimulus.
    initial begin
        in_ch.valid = 1'b0;
        in_ch.target_found = 1'b0;
        in_ch.centre_x = '0;
        in_ch.object_height = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames with the reset gains: searching, both sides of the dead band,
        // the arrival margin, heights at both ends and centres beyond the image.
        gap_pct = 20;
        stall_pct = 20;
        push_frame(1'b0, 10'd0, 10'd0);
        push_frame(1'b0, 10'd1023, 10'd1023);
        push_frame(1'b1, 10'd0, 10'd300);
        push_frame(1'b1, 10'd639, 10'd300);
        push_frame(1'b1, 10'd1023, 10'd0);
        push_frame(1'b1, 10'd280, 10'd300);
        push_frame(1'b1, 10'd281, 10'd300);
        push_frame(1'b1, 10'd360, 10'd300);
        push_frame(1'b1, 10'd359, 10'd0);
        push_frame(1'b1, 10'd320, 10'd290);
        push_frame(1'b1, 10'd320, 10'd291);
        push_frame(1'b1, 10'd320, 10'd1023);
        push_frame(1'b1, 10'd320, 10'd0);
        push_frame(1'b0, 10'd512, 10'd512);
        push_frame(1'b1, 10'd320, 10'd100);
        push_frame(1'b1, 10'd0, 10'd1023);

        // Phases of random frames, each under its own setting.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            if (phase > 0) program_setting(phase);
            if (phase == PHASES - 1) begin
                quiet = 1'b1;
            end else if (phase % 3 == 2) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = 30;
                stall_pct = 30;
            end
            // Hold the receiver off while frames keep coming, so the block backs up.
            if (phase == 1) begin
                hold_req = 1'b1;
                repeat (30) random_frame();
            end
            random_frames(PHASE_FRAMES);
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/vsp_pkg.sv
rtl/vsp_if.sv
rtl/visual_servo_pid_steering_top.sv
rtl/vsp_checker.sv
tb/sv/vsp_steer_checker.sv
tb/sv/testbench.sv
